@@ src/assert_macros.svh @@
// Assertion macros shared by the command frame checker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition on the cycle after a trigger, off while reset is held
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cfc_pkg.sv @@
// Types, constants and functions of the command frame checker
package cfc_pkg;

    localparam logic [7:0] CRC_INIT  = 8'hFF;
    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [3:0] COUNT_MAX = 4'd15;

    typedef enum logic [2:0] {
        FAULT_NONE    = 3'd0,
        FAULT_SHORT   = 3'd1,
        FAULT_UNKNOWN = 3'd2,
        FAULT_LENGTH  = 3'd3,
        FAULT_CRC     = 3'd4
    } fault_t;

    typedef struct packed {
        logic   frame_ok;
        fault_t fault;
    } verdict_t;

    typedef struct packed {
        logic       known;
        logic [2:0] body;
    } id_info_t;

    function automatic id_info_t id_lookup(input logic [7:0] id);
        id_info_t info;
        info.known = 1'b1;
        unique case (id)
            8'h01: info.body = 3'd4;
            8'h02, 8'h04, 8'h05, 8'h0E, 8'h0C, 8'h0D: info.body = 3'd2;
            8'h06: info.body = 3'd7;
            8'h0A, 8'h84, 8'h8E, 8'h8C: info.body = 3'd1;
            8'h0F, 8'h83, 8'h85, 8'h87,
            8'h88, 8'h89, 8'h8A, 8'h8B: info.body = 3'd0;
            default: begin
                info.known = 1'b0;
                info.body  = 3'd0;
            end
        endcase
        return info;
    endfunction

    // MSB-first CRC-8 update, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ src/cfc_frame_track.sv @@
// Per-frame state: running CRC, byte count, id lookup and verdict
`include "assert_macros.svh"

module cfc_frame_track (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output cfc_pkg::verdict_t verdict
);

    logic [7:0] crc_reg, crc_next;
    logic [3:0] count_reg, count_next;
    logic [2:0] body_reg, body_next;
    logic       unknown_reg, unknown_next;
    cfc_pkg::id_info_t info;
    cfc_pkg::fault_t   fault;

    assign info = cfc_pkg::id_lookup(data_byte);

    always_comb begin
        crc_next     = crc_reg;
        count_next   = count_reg;
        body_next    = body_reg;
        unknown_next = unknown_reg;
        if (step) begin
            if (last_byte) begin
                crc_next     = cfc_pkg::CRC_INIT;
                count_next   = 4'd0;
                body_next    = 3'd0;
                unknown_next = 1'b0;
            end else begin
                if (count_reg == 4'd0) begin
                    body_next    = info.body;
                    unknown_next = !info.known;
                end
                crc_next = cfc_pkg::crc8_update(crc_reg, data_byte);
                if (count_reg != cfc_pkg::COUNT_MAX) begin
                    count_next = count_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= cfc_pkg::CRC_INIT;
            count_reg   <= 4'd0;
            body_reg    <= 3'd0;
            unknown_reg <= 1'b0;
        end else begin
            crc_reg     <= crc_next;
            count_reg   <= count_next;
            body_reg    <= body_next;
            unknown_reg <= unknown_next;
        end
    end

    // frame total is id + body + crc, so count of non-final bytes must equal body + 1
    always_comb begin
        priority if (count_reg == 4'd0) begin
            fault = cfc_pkg::FAULT_SHORT;
        end else if (unknown_reg) begin
            fault = cfc_pkg::FAULT_UNKNOWN;
        end else if (count_reg != ({1'b0, body_reg} + 4'd1)) begin
            fault = cfc_pkg::FAULT_LENGTH;
        end else if (crc_reg != data_byte) begin
            fault = cfc_pkg::FAULT_CRC;
        end else begin
            fault = cfc_pkg::FAULT_NONE;
        end
    end

    assign verdict.fault    = fault;
    assign verdict.frame_ok = (fault == cfc_pkg::FAULT_NONE);

    `ASSERT_NEXT(a_clear_after_verdict, step && last_byte, count_reg == 4'd0 && crc_reg == cfc_pkg::CRC_INIT, "frame state not cleared")
    `ASSERT_CLK(a_unknown_body_zero, unknown_reg |-> body_reg == 3'd0, "unknown id with nonzero body length")

endmodule

@@ src/cfc_result_reg.sv @@
// Result register holding one verdict until the receiver takes it
`include "assert_macros.svh"

module cfc_result_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  cfc_pkg::verdict_t verdict,
    output logic              out_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata     // [0] frame_ok, [3:1] fault, [7:4] zero
);

    logic              valid_reg, valid_next;
    cfc_pkg::verdict_t verdict_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            verdict_reg <= verdict;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, verdict_reg.fault, verdict_reg.frame_ok};

    `ASSERT_CLK(a_no_overwrite, load |-> out_free, "verdict loaded over an untaken one")
    `ASSERT_CLK(a_ok_matches_fault, valid_reg |-> verdict_reg.frame_ok == (verdict_reg.fault == cfc_pkg::FAULT_NONE), "frame_ok disagrees with fault")
    `ASSERT_CLK(a_fault_range, valid_reg |-> verdict_reg.fault <= cfc_pkg::FAULT_CRC, "fault code out of range")

endmodule

@@ src/command_frame_checker.sv @@
// Top level of the command frame checker
//
// Frames [id][body][crc] arrive one byte per transfer on the s_ channel,
// with s_tlast on the CRC byte. The id sets the expected body length; a
// CRC-8 (poly 0x07, init 0xFF) covers every byte but the last. Each frame
// yields one verdict transfer on the m_ channel: frame_ok and a fault code
// (0 ok, 1 too short, 2 unknown id, 3 wrong length, 4 CRC mismatch).
// Non-final bytes give no output transfer.
// Throughput: one byte per cycle while no final byte waits on a full
// result register; the CRC step and id lookup sit in a single stage after
// the input register. A final byte is held in the input register, and
// its verdict then in the result register, which drives m_tvalid.
// When the receiver stalls, the verdict holds in the result register and
// the input register keeps taking non-final bytes; a final byte waits in
// the input register, and s_tready drops only once that stage is full.
// Synchronous reset (aresetn low) empties both registers and returns the
// frame state to its start: CRC 0xFF, no bytes counted.
module command_frame_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] frame_ok, [3:1] fault, [7:4] zero
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_data_reg;
    logic              in_last_reg;
    logic              out_free;
    logic              advance;
    cfc_pkg::verdict_t verdict;

    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    cfc_frame_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .verdict   (verdict)
    );

    cfc_result_reg u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && in_last_reg),
        .verdict  (verdict),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
